FILE: src/b64se_pkg.sv
package b64se_pkg;

   localparam logic [6:0] PAD_CHAR  = 7'h3D;
   localparam logic [1:0] LAST_SLOT = 2'd3;

   // one encoded group waiting for the character stage
   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  pads;
      logic        last;
   } group_entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
      logic [6:0] c;
      case (v) inside
         [6'd0:6'd25]:  c = 7'd65 + 7'(v);
         [6'd26:6'd51]: c = 7'd97 + 7'(v - 6'd26);
         [6'd52:6'd61]: c = 7'd48 + 7'(v - 6'd52);
         6'd62:         c = 7'h2B;
         default:       c = 7'h2F;
      endcase
      return c;
   endfunction

endpackage

FILE: src/b64se_front.sv
module b64se_front
   import b64se_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_is_final,
   input  queue_status_type q_status,
   output logic             push,
   output group_entry_type  push_entry
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  cnt;
   logic        accept;

   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;
   // a count of three never occurs; treat it as two pending bytes
   assign cnt       = (count_ff == 2'd3) ? 2'd2 : count_ff;

   always_comb begin
      held_in    = held_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_entry = '0;
      case (cnt)
         2'd0: begin
            push_entry.group = {req_data_byte, 16'h0000};
            push_entry.pads  = 2'd2;
         end
         2'd1: begin
            push_entry.group = {held_ff[15:8], req_data_byte, 8'h00};
            push_entry.pads  = 2'd1;
         end
         default: begin
            push_entry.group = {held_ff, req_data_byte};
            push_entry.pads  = 2'd0;
         end
      endcase
      push_entry.last = req_is_final;
      if (accept) begin
         if (!req_is_final && cnt != 2'd2) begin
            if (cnt == 2'd0) begin
               held_in = {req_data_byte, 8'h00};
            end else begin
               held_in = {held_ff[15:8], req_data_byte};
            end
            count_in = cnt + 2'd1;
         end else begin
            push     = 1'b1;
            held_in  = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         count_ff <= '0;
      end else begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/b64se_queue.sv
module b64se_queue
   import b64se_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  group_entry_type  push_entry,
   input  logic             pop,
   output group_entry_type  head_entry,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   group_entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign q_status.not_full  = (fill_ff != FULL_CNT);
   assign q_status.not_empty = (fill_ff != '0);
   assign do_push            = push && q_status.not_full;
   assign do_pop             = pop && q_status.not_empty;
   assign head_entry         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/b64se_back.sv
module b64se_back
   import b64se_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  group_entry_type  head_entry,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [6:0]       rsp_out_char,
   output logic             rsp_last_char
);

   group_entry_type entry_ff, entry_in;
   logic [1:0]      slot_ff, slot_in;
   logic            busy_ff, busy_in;
   logic            valid_ff, valid_in;
   logic [6:0]      char_ff, char_in;
   logic            last_ff, last_in;

   group_entry_type cur;
   logic [1:0]      cur_slot;
   logic            have, load;
   logic [5:0]      sextet;
   logic            is_pad;

   assign load     = !valid_ff || rsp_ready;
   assign have     = busy_ff || q_status.not_empty;
   assign cur      = busy_ff ? entry_ff : head_entry;
   assign cur_slot = busy_ff ? slot_ff : 2'd0;
   assign pop      = !busy_ff && load && q_status.not_empty;

   always_comb begin
      case (cur_slot)
         2'd0:    sextet = cur.group[23:18];
         2'd1:    sextet = cur.group[17:12];
         2'd2:    sextet = cur.group[11:6];
         default: sextet = cur.group[5:0];
      endcase
      is_pad = ((cur_slot == LAST_SLOT) && (cur.pads != 2'd0)) ||
               ((cur_slot == 2'd2) && (cur.pads == 2'd2));
   end

   always_comb begin
      entry_in = entry_ff;
      slot_in  = slot_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = have;
         if (have) begin
            char_in  = is_pad ? PAD_CHAR : sextet_to_char(sextet);
            last_in  = cur.last && (cur_slot == LAST_SLOT);
            entry_in = cur;
            slot_in  = cur_slot + 2'd1;
            busy_in  = (cur_slot != LAST_SLOT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

FILE: src/base64_stream_encoder.sv
// streaming base64 encoder, standard alphabet with '=' padding. one message
// byte per req transaction, with req_is_final on the last byte of the message;
// one ascii character per rsp transaction, rsp_last_char set on the final
// character. the front stage gathers bytes into groups of three and takes a
// byte every cycle while the group queue has room; each full or final group
// becomes one queue entry. the back stage turns an entry into four characters,
// one per cycle while rsp_ready allows, through a single output register, so
// the sustained rate is set by the rsp channel. for a byte that completes a
// group, the group is written into the queue and then its first character into
// the output register, where rsp_valid rises with it.
// QUEUE_DEPTH sets how many groups can wait between the stages.
module base64_stream_encoder
   import b64se_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   // byte transactions
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_final,
   // character transactions
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char
);

   // front to queue
   logic             push;
   group_entry_type  push_entry;
   // queue to back
   logic             pop;
   group_entry_type  head_entry;
   queue_status_type q_status;

   // byte gathering and group classification
   b64se_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_is_final  (req_is_final),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // decouples byte intake from character output
   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // character sequencer with registered output
   b64se_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_entry    (head_entry),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: src/b64se_checker.sv
module b64se_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_is_final,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char
);

   // stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_last_char))
      else $error("rsp payload changed while stalled");

   // only alphabet or pad characters
   a_rsp_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char >= 7'd65 && rsp_out_char <= 7'd90) ||
                    (rsp_out_char >= 7'd97 && rsp_out_char <= 7'd122) ||
                    (rsp_out_char >= 7'd48 && rsp_out_char <= 7'd57) ||
                    (rsp_out_char == 7'h2B) || (rsp_out_char == 7'h2F) ||
                    (rsp_out_char == 7'h3D))
      else $error("rsp character outside base64 set");

   // no character out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

   // stalled byte holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte)
                                  && $stable(req_is_final))
      else $error("req payload changed while stalled");

   // a final character closes its group, so the next one cannot be final
   a_last_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_char |=> !(rsp_valid && rsp_last_char))
      else $error("final character followed by another final character");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_data_byte (req_data_byte),
   .req_is_final  (req_is_final),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char)
);
